@@ rtl/triangle_mesh_binary_parser_top_defines.svh @@
// Assertion macros shared by the triangle mesh parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TRIANGLE_MESH_BINARY_PARSER_TOP_DEFINES_SVH
`define TRIANGLE_MESH_BINARY_PARSER_TOP_DEFINES_SVH

// Check on every clock edge outside reset.
`define TMBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define TMBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/tmbp_pkg.sv @@
// Shared types and constants for the triangle mesh binary parser.
// No dependencies.
package tmbp_pkg;

  typedef enum logic [2:0] {
    KIND_VERTEX   = 3'd0,
    KIND_INDEX    = 3'd1,
    KIND_HEADER   = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_NONFINITE = 3'd2;
  localparam logic [2:0] ERR_RANGE     = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  localparam logic [23:0] SIGNATURE    = 24'hFFFFFE;
  localparam logic [7:0]  NEWLINE      = 8'h0A;
  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word_value;
    logic [31:0] element_number;
    logic [1:0]  position;
    logic [2:0]  error_code;
    logic        last;
  } res_t;

  localparam res_t RES_ZERO = '{kind: KIND_VERTEX, word_value: 32'd0,
                                element_number: 32'd0, position: 2'd0,
                                error_code: ERR_NONE, last: 1'b0};

endpackage

@@ rtl/triangle_mesh_binary_parser_top.sv @@
// Timing: a result is written into the registered result queue when its input byte is accepted.
// Throughput: one input byte per cycle while in_stall is low; a step with two results drains
// through a three-entry result queue, and in_stall rises only when that queue lacks room.
// Reset: synchronous active-low rst_n returns the parser to the signature phase and
// empties the result queue; no clearing pass.
module triangle_mesh_binary_parser_top
  import tmbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_word_value,
  output logic [31:0] out_element_number,
  output logic [1:0]  out_position,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  logic       fire, take_ok;
  logic [1:0] res_cnt, push_cnt;
  res_t       res0, res1, head;

  assign in_stall = !take_ok;
  assign fire     = in_valid && take_ok;
  assign push_cnt = fire ? res_cnt : 2'd0;

  tmbp_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_data_byte),
    .first_byte    (in_first_byte),
    .end_of_stream (in_end_of_stream),
    .res_cnt       (res_cnt),
    .res0          (res0),
    .res1          (res1)
  );

  tmbp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .take_ok   (take_ok)
  );

  assign out_kind           = head.kind;
  assign out_word_value     = head.word_value;
  assign out_element_number = head.element_number;
  assign out_position       = head.position;
  assign out_error_code     = head.error_code;
  assign out_last           = head.last;

endmodule

@@ rtl/tmbp_step.sv @@
// Parser state and per-byte decode: turns one accepted byte into up to two results.
// Depends on tmbp_pkg and the assertion macro header.
`include "triangle_mesh_binary_parser_top_defines.svh"
module tmbp_step
  import tmbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       end_of_stream,
  output logic [1:0] res_cnt,
  output res_t       res0,
  output res_t       res1
);

  typedef enum logic [2:0] {
    PH_SIG     = 3'd0,
    PH_COMMENT = 3'd1,
    PH_VCOUNT  = 3'd2,
    PH_FCOUNT  = 3'd3,
    PH_VERTS   = 3'd4,
    PH_FACES   = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [1:0]  biw_r, biw_nxt, biw, biw_inc;
  logic [31:0] ws_r, ws_nxt, ws, ws_sh;
  logic [31:0] vt_r, vt_nxt, vt;
  logic [31:0] ft_r, ft_nxt, ft;
  logic [31:0] ec_r, ec_nxt, ec, ec_inc;
  logic [1:0]  ac_r, ac_nxt, ac;
  logic        pn_r, pn_nxt, pn;
  logic        is_nl;

  // restart folds the reset values in before the byte is decoded
  always_comb begin
    ph  = first_byte ? PH_SIG : phase_r;
    biw = first_byte ? 2'd0 : biw_r;
    ws  = first_byte ? 32'd0 : ws_r;
    vt  = first_byte ? 32'd0 : vt_r;
    ft  = first_byte ? 32'd0 : ft_r;
    ec  = first_byte ? 32'd0 : ec_r;
    ac  = first_byte ? 2'd0 : ac_r;
    pn  = first_byte ? 1'b0 : pn_r;
    ws_sh   = {ws[23:0], data_byte};
    biw_inc = biw + 2'd1;
    ec_inc  = ec + 32'd1;
    is_nl   = (data_byte == NEWLINE);
  end

  always_comb begin
    phase_nxt = phase_r;
    biw_nxt   = biw_r;
    ws_nxt    = ws_r;
    vt_nxt    = vt_r;
    ft_nxt    = ft_r;
    ec_nxt    = ec_r;
    ac_nxt    = ac_r;
    pn_nxt    = pn_r;
    res_cnt   = 2'd0;
    res0      = RES_ZERO;
    res1      = RES_ZERO;
    res1.kind = KIND_COMPLETE;
    res1.last = 1'b1;

    if (end_of_stream) begin
      if (!(phase_r inside {PH_DONE, PH_ERROR})) begin
        res_cnt         = 2'd1;
        res0.kind       = KIND_ERROR;
        res0.error_code = ERR_TRUNCATED;
        res0.last       = 1'b1;
        phase_nxt       = PH_ERROR;
      end
    end else begin
      phase_nxt = ph;
      biw_nxt   = biw;
      ws_nxt    = ws;
      vt_nxt    = vt;
      ft_nxt    = ft;
      ec_nxt    = ec;
      ac_nxt    = ac;
      pn_nxt    = pn;
      case (ph)
        PH_SIG: begin
          ws_nxt  = ws_sh;
          biw_nxt = biw_inc;
          if (biw_inc == 2'd3) begin
            biw_nxt = 2'd0;
            ws_nxt  = 32'd0;
            if (ws_sh[23:0] != SIGNATURE) begin
              res_cnt         = 2'd1;
              res0.kind       = KIND_ERROR;
              res0.word_value = {8'd0, ws_sh[23:0]};
              res0.error_code = ERR_SIGNATURE;
              res0.last       = 1'b1;
              phase_nxt       = PH_ERROR;
            end else begin
              phase_nxt = PH_COMMENT;
              pn_nxt    = 1'b0;
            end
          end
        end
        PH_COMMENT: begin
          if (is_nl && pn) begin
            phase_nxt = PH_VCOUNT;
            biw_nxt   = 2'd0;
            ws_nxt    = 32'd0;
          end
          pn_nxt = is_nl;
        end
        PH_VCOUNT, PH_FCOUNT, PH_VERTS, PH_FACES: begin
          ws_nxt  = ws_sh;
          biw_nxt = biw_inc;
          // a word is complete when the byte counter wraps
          if (biw_inc == 2'd0) begin
            case (ph)
              PH_VCOUNT: begin
                vt_nxt    = ws_sh;
                phase_nxt = PH_FCOUNT;
              end
              PH_FCOUNT: begin
                ft_nxt              = ws_sh;
                res_cnt             = 2'd1;
                res0.kind           = KIND_HEADER;
                res0.word_value     = vt;
                res0.element_number = ws_sh;
                ec_nxt              = 32'd0;
                ac_nxt              = 2'd0;
                ws_nxt              = 32'd0;
                if (vt != 32'd0) begin
                  phase_nxt = PH_VERTS;
                end else if (ws_sh != 32'd0) begin
                  phase_nxt = PH_FACES;
                end else begin
                  res_cnt   = 2'd2;
                  phase_nxt = PH_DONE;
                end
              end
              PH_VERTS: begin
                res_cnt             = 2'd1;
                res0.word_value     = ws_sh;
                res0.element_number = ec;
                res0.position       = ac;
                if (ws_sh[30:23] == EXP_ALL_ONES) begin
                  res0.kind       = KIND_ERROR;
                  res0.error_code = ERR_NONFINITE;
                  res0.last       = 1'b1;
                  phase_nxt       = PH_ERROR;
                end else begin
                  res0.kind = KIND_VERTEX;
                  ac_nxt    = ac + 2'd1;
                  if (ac == 2'd2) begin
                    ac_nxt = 2'd0;
                    ec_nxt = ec_inc;
                    if (ec_inc == vt) begin
                      ec_nxt = 32'd0;
                      ws_nxt = 32'd0;
                      if (ft != 32'd0) begin
                        phase_nxt = PH_FACES;
                      end else begin
                        res_cnt   = 2'd2;
                        phase_nxt = PH_DONE;
                      end
                    end
                  end
                end
              end
              default: begin
                res_cnt             = 2'd1;
                res0.word_value     = ws_sh;
                res0.element_number = ec;
                res0.position       = ac;
                if (ws_sh >= vt) begin
                  res0.kind       = KIND_ERROR;
                  res0.error_code = ERR_RANGE;
                  res0.last       = 1'b1;
                  phase_nxt       = PH_ERROR;
                end else begin
                  res0.kind = KIND_INDEX;
                  ac_nxt    = ac + 2'd1;
                  if (ac == 2'd2) begin
                    ac_nxt = 2'd0;
                    ec_nxt = ec_inc;
                    if (ec_inc == ft) begin
                      res_cnt   = 2'd2;
                      phase_nxt = PH_DONE;
                    end
                  end
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      biw_r   <= 2'd0;
      ws_r    <= 32'd0;
      vt_r    <= 32'd0;
      ft_r    <= 32'd0;
      ec_r    <= 32'd0;
      ac_r    <= 2'd0;
      pn_r    <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      biw_r   <= biw_nxt;
      ws_r    <= ws_nxt;
      vt_r    <= vt_nxt;
      ft_r    <= ft_nxt;
      ec_r    <= ec_nxt;
      ac_r    <= ac_nxt;
      pn_r    <= pn_nxt;
    end
  end

  `TMBP_ASSERT(a_last_ends_file, fire && res_cnt == 2'd1 && res0.last |=> phase_r == PH_DONE || phase_r == PH_ERROR, "last result without done or error phase")
  `TMBP_ASSERT(a_pair_tail, res_cnt == 2'd2 |-> res0.kind == KIND_HEADER || res0.kind == KIND_VERTEX || res0.kind == KIND_INDEX, "bad first result of a pair")
  `TMBP_ASSERT(a_axis_range, ac_r != 2'd3, "axis counter out of range")

endmodule

@@ rtl/tmbp_outq.sv @@
// Three-entry result queue between the parser step and the result channel.
// Depends on tmbp_pkg and the assertion macro header.
`include "triangle_mesh_binary_parser_top_defines.svh"
module tmbp_outq
  import tmbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  res_t       push0,
  input  res_t       push1,
  input  logic       out_stall,
  output logic       out_valid,
  output res_t       head,
  output logic       take_ok
);

  res_t       q_r [3];
  res_t       q_nxt [3];
  res_t       sh [3];
  logic [1:0] cnt_r, cnt_nxt, base;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign base      = cnt_r - {1'b0, pop};
  // room for a two-result step after this cycle's pop
  assign take_ok   = (base <= 2'd1);
  assign cnt_nxt   = base + push_cnt;

  always_comb begin
    sh[0] = pop ? q_r[1] : q_r[0];
    sh[1] = pop ? q_r[2] : q_r[1];
    sh[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (2'(i) == base && push_cnt != 2'd0) begin
        q_nxt[i] = push0;
      end else if (2'(i) == base + 2'd1 && push_cnt == 2'd2) begin
        q_nxt[i] = push1;
      end else begin
        q_nxt[i] = sh[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `TMBP_ASSERT(a_push_fits, push_cnt != 2'd0 |-> take_ok, "push into a queue without room")
  `TMBP_ASSERT(a_head_holds, out_valid && out_stall |=> out_valid && $stable(head), "stalled head changed")
  `TMBP_ASSERT(a_pop_drains, pop && push_cnt == 2'd0 |=> cnt_r == $past(cnt_r) - 2'd1, "pop did not drain one word")

endmodule
